// File: hdl/lfo_sine_triangle_generator_assert.svh
// Assertion macros used by the checker file of the LFO block.
// Needs nothing else; every macro expands to one concurrent assertion.
`ifndef LFO_SINE_TRIANGLE_GENERATOR_ASSERT_SVH
`define LFO_SINE_TRIANGLE_GENERATOR_ASSERT_SVH

// antecedent and consequent in the same cycle
`define LFOST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lfost assertion failed");

// consequent in the cycle after the antecedent
`define LFOST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lfost assertion failed");

`endif

// File: hdl/lfost_pkg.sv
// Shared types, constants and helpers of the LFO sine/triangle generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package lfost_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 24;
  localparam int OSC_FRAC         = 28;
  localparam int STATE_W          = 32;
  localparam int RND_W            = STATE_W + 8;  // holds any rounded product
  localparam int SUM_W            = RND_W + 1;
  localparam int CFG_IDX_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RISE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FALL   = 3'd7;

  localparam logic MODE_SINE = 1'b0;

  // one multiply/accumulate pair of the sine update each
  typedef enum logic [1:0] {
    STEP_T = 2'd0,  // t = c - k1*s
    STEP_S = 2'd1,  // s = s + k2*t
    STEP_C = 2'd2,  // c = t - k1*s
    STEP_X = 2'd3   // x = amp*s + offset
  } step_t;

  typedef struct packed {
    logic  start;    // word accepted: apply restart
    logic  mul;      // load product register
    logic  acc;      // round product and update state
    step_t step;
    logic  tri_upd;  // triangle level update
    logic  tri_ofs;  // add offset to triangle level
    logic  load;     // clip and load output register
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
  } dp_stat_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic ovf;
    ovf = !((&v[SUM_W-1:STATE_W-1]) || (~|v[SUM_W-1:STATE_W-1]));
    if (!ovf) begin
      return v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: hdl/lfost_ctrl.sv
// Sequencer of the LFO generator: walks the shared multiplier through the
// sine steps or runs the triangle update, and owns both handshakes. Uses lfost_pkg.
module lfost_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lfost_pkg::dp_stat_t stat,
  output lfost_pkg::dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_TRI  = 6'b001000,
    S_TOFS = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  lfost_pkg::step_t step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             load;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // output register is free when empty or drained this cycle
  assign load      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (stat.mode == lfost_pkg::MODE_SINE) ? S_MUL : S_TRI;
          step_nxt  = lfost_pkg::STEP_T;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (step_r == lfost_pkg::STEP_X) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
          step_nxt  = lfost_pkg::step_t'(step_r + 2'd1);
        end
      end
      S_TRI:  state_nxt = S_TOFS;
      S_TOFS: state_nxt = S_DONE;
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.start   = accept;
    cmd.mul     = (state_r == S_MUL);
    cmd.acc     = (state_r == S_ACC);
    cmd.step    = step_r;
    cmd.tri_upd = (state_r == S_TRI);
    cmd.tri_ofs = (state_r == S_TOFS);
    cmd.load    = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= lfost_pkg::STEP_T;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/lfost_dp.sv
// Datapath of the LFO generator: configuration registers, oscillator and
// triangle state, one shared multiplier, rounding, saturation and clipping. Uses lfost_pkg.
module lfost_dp #(
  parameter int SAMPLE_WIDTH = lfost_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = lfost_pkg::COEF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lfost_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [2*SAMPLE_WIDTH-1:0]           cfg_data,
  input  logic                                in_restart,
  input  lfost_pkg::dp_cmd_t                  cmd,
  output lfost_pkg::dp_stat_t                 stat,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COEF_WIDTH;
  localparam int STW    = lfost_pkg::STATE_W;
  localparam int SUMW   = lfost_pkg::SUM_W;
  localparam int RNDW   = lfost_pkg::RND_W;
  localparam int OPA_W  = ((CW > SW - 1) ? CW : SW - 1) + 1;
  localparam int PROD_W = OPA_W + STW;

  localparam logic signed [PROD_W:0]   HALF_K  = (PROD_W + 1)'(1) << (CW - 2);
  localparam logic signed [PROD_W:0]   HALF_A  = (PROD_W + 1)'(1) << (lfost_pkg::OSC_FRAC - 1);
  localparam logic signed [STW-1:0]    ONE_OSC = STW'(1) << lfost_pkg::OSC_FRAC;
  localparam logic signed [SW-1:0]     SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]     SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  // configuration
  logic                   mode_r;
  logic [CW-1:0]          coef_a_r, coef_b_r;
  logic [SW-2:0]          amp_r, rise_r;
  logic signed [SW-1:0]   offset_r, fall_r, clip_hi_r, clip_lo_r;

  // state
  logic signed [STW-1:0]  cos_r, sin_r, t_r, tri_r;
  logic                   falling_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUMW-1:0] x_r;
  logic signed [SW-1:0]   sample_r;

  // multiplier
  logic signed [OPA_W-1:0]  opa;
  logic signed [STW-1:0]    opb;
  logic signed [PROD_W-1:0] prod_nxt;

  // accumulate
  logic signed [PROD_W:0]   prod_ext, rsum;
  logic signed [PROD_W:0]   rsh;
  logic signed [SUMW-1:0]   rnd, base, acc_sum;
  logic signed [STW-1:0]    acc_sat;

  // triangle
  logic signed [SUMW-1:0]   lvl_e, amp_e, step_e, tri_sum;
  logic                     fall_nxt;

  // clip
  logic signed [SUMW-1:0]   hi_e, lo_e, clip1, clip2;

  assign stat.mode  = mode_r;
  assign out_sample = sample_r;

  always_comb begin
    unique case (cmd.step)
      lfost_pkg::STEP_T: begin
        opa = signed'(OPA_W'(coef_a_r));
        opb = sin_r;
      end
      lfost_pkg::STEP_S: begin
        opa = signed'(OPA_W'(coef_b_r));
        opb = t_r;
      end
      lfost_pkg::STEP_C: begin
        opa = signed'(OPA_W'(coef_a_r));
        opb = sin_r;
      end
      lfost_pkg::STEP_X: begin
        opa = signed'(OPA_W'(amp_r));
        opb = sin_r;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_nxt = opa * opb;

  // round to nearest, ties up, then arithmetic shift
  assign prod_ext = (PROD_W + 1)'(prod_r);
  assign rsum     = prod_ext + ((cmd.step == lfost_pkg::STEP_X) ? HALF_A : HALF_K);
  assign rsh      = (cmd.step == lfost_pkg::STEP_X) ? (rsum >>> lfost_pkg::OSC_FRAC)
                                                    : (rsum >>> (CW - 1));
  assign rnd      = SUMW'(signed'(rsh[RNDW-1:0]));

  always_comb begin
    unique case (cmd.step)
      lfost_pkg::STEP_T: base = SUMW'(cos_r);
      lfost_pkg::STEP_S: base = SUMW'(sin_r);
      lfost_pkg::STEP_C: base = SUMW'(t_r);
      lfost_pkg::STEP_X: base = SUMW'(offset_r);
      default:           base = '0;
    endcase
  end

  assign acc_sum = ((cmd.step == lfost_pkg::STEP_T) || (cmd.step == lfost_pkg::STEP_C))
                   ? (base - rnd) : (base + rnd);
  assign acc_sat = lfost_pkg::sat_state(acc_sum);

  // triangle turn points at +/- amplitude; zero level with zero amplitude turns down
  assign lvl_e = SUMW'(tri_r);
  assign amp_e = SUMW'(signed'({1'b0, amp_r}));
  always_comb begin
    if (lvl_e >= amp_e) begin
      fall_nxt = 1'b1;
    end else if (lvl_e <= -amp_e) begin
      fall_nxt = 1'b0;
    end else begin
      fall_nxt = falling_r;
    end
  end
  assign step_e  = fall_nxt ? SUMW'(fall_r) : SUMW'(signed'({1'b0, rise_r}));
  assign tri_sum = lvl_e + step_e;

  // high clip first, low clip wins when crossed
  assign hi_e  = SUMW'(clip_hi_r);
  assign lo_e  = SUMW'(clip_lo_r);
  assign clip1 = (x_r > hi_e) ? hi_e : x_r;
  assign clip2 = (clip1 < lo_e) ? lo_e : clip1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lfost_pkg::MODE_SINE;
      coef_a_r  <= '0;
      coef_b_r  <= '0;
      amp_r     <= '0;
      offset_r  <= '0;
      clip_hi_r <= SMP_MAX;
      clip_lo_r <= SMP_MIN;
      rise_r    <= '0;
      fall_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfost_pkg::REG_MODE:   mode_r   <= cfg_data[0];
        lfost_pkg::REG_COEF_A: coef_a_r <= cfg_data[CW-1:0];
        lfost_pkg::REG_COEF_B: coef_b_r <= cfg_data[CW-1:0];
        lfost_pkg::REG_AMP:    amp_r    <= cfg_data[SW-2:0];
        lfost_pkg::REG_OFFSET: offset_r <= signed'(cfg_data[SW-1:0]);
        lfost_pkg::REG_CLIP: begin
          clip_lo_r <= signed'(cfg_data[SW-1:0]);
          clip_hi_r <= signed'(cfg_data[2*SW-1:SW]);
        end
        lfost_pkg::REG_RISE:   rise_r   <= cfg_data[SW-2:0];
        lfost_pkg::REG_FALL:   fall_r   <= signed'(cfg_data[SW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r     <= ONE_OSC;
      sin_r     <= '0;
      tri_r     <= '0;
      falling_r <= 1'b0;
    end else if (cmd.start) begin
      if (in_restart) begin
        if (mode_r == lfost_pkg::MODE_SINE) begin
          cos_r <= ONE_OSC;
          sin_r <= '0;
        end else begin
          tri_r     <= '0;
          falling_r <= 1'b0;
        end
      end
    end else if (cmd.acc) begin
      if (cmd.step == lfost_pkg::STEP_S) begin
        sin_r <= acc_sat;
      end else if (cmd.step == lfost_pkg::STEP_C) begin
        cos_r <= acc_sat;
      end
    end else if (cmd.tri_upd) begin
      tri_r     <= lfost_pkg::sat_state(tri_sum);
      falling_r <= fall_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc && (cmd.step == lfost_pkg::STEP_T)) begin
      t_r <= acc_sat;
    end
    if (cmd.acc && (cmd.step == lfost_pkg::STEP_X)) begin
      x_r <= acc_sum;
    end else if (cmd.tri_ofs) begin
      x_r <= SUMW'(tri_r) + SUMW'(offset_r);
    end
    if (cmd.load) begin
      sample_r <= clip2[SW-1:0];
    end
  end

endmodule

// File: hdl/lfo_sine_triangle_generator.sv
// LFO sample generator. One word in (restart flag) gives one sample word out.
// Sine mode: the recursive quadrature update and the amplitude scale are four
// multiplies in series on one shared multiplier, each a multiply step and a
// round/saturate step, between accept and clip/output. Triangle mode: accept,
// level update, offset add, clip/output. A new word is taken once the last
// has passed clip/output, even while its sample still waits in the output
// register. Configuration is to be written through cfg_we/cfg_index/cfg_data
// while the block is idle, by the user; the block itself does not enforce it.
module lfo_sine_triangle_generator #(
  parameter int SAMPLE_WIDTH = lfost_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = lfost_pkg::COEF_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfost_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [2*SAMPLE_WIDTH-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  out_sample
);

  lfost_pkg::dp_cmd_t  cmd;
  lfost_pkg::dp_stat_t stat;

  lfost_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfost_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_restart (in_restart),
    .cmd        (cmd),
    .stat       (stat),
    .out_sample (out_sample)
  );

endmodule

// File: hdl/lfost_checker.sv
// Port-level checks for the LFO generator and the bind that attaches them.
// Uses the macros of lfo_sine_triangle_generator_assert.svh.
`include "lfo_sine_triangle_generator_assert.svh"

module lfost_checker #(
  parameter int SAMPLE_WIDTH = lfost_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample
);

  // a stalled result word holds
  `LFOST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample))
  // one word at a time: busy right after an accept
  `LFOST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // a result appears only at the end of a computation
  `LFOST_ASSERT_NOW(a_out_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind lfo_sine_triangle_generator lfost_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lfost_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample)
);
